// File: design/bbi_pkg.sv
// ----------------------------------------------------------------------------
// bbi_pkg
// Shared widths, request codes and interface types of the beam bilinear
// interpolator: grid geometry, table banking and datapath word formats.
// ----------------------------------------------------------------------------
package bbi_pkg;

  // grid and table geometry
  localparam int GRID_SIDE_MAX = 64;
  localparam int NUM_ANTENNAS  = 16;
  localparam int COORD_W       = $clog2(GRID_SIDE_MAX);
  localparam int HALF_W        = COORD_W - 1;
  localparam int ANT_W         = $clog2(NUM_ANTENNAS);
  localparam int SIDE_W        = COORD_W + 1;
  localparam int NUM_BANKS     = 4;
  localparam int BANK_AW       = ANT_W + 2 * HALF_W;
  localparam int BANK_DEPTH    = 1 << BANK_AW;

  // number formats
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int ROW_W    = SAMPLE_W + FRAC_W;
  localparam int ACC_W    = ROW_W + FRAC_W;

  localparam logic [SIDE_W-1:0] GRID_SIDE_RESET = SIDE_W'(63);

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [NUM_BANKS-1:0][SAMPLE_W-1:0] quad_t;

  // neighbour indices and fraction along one axis
  typedef struct packed {
    logic [COORD_W-1:0] i0;
    logic [COORD_W-1:0] i1;
    logic [FRAC_W-1:0]  frac;
  } loc_t;

  // query control handed to the blend datapath alongside the bank words
  typedef struct packed {
    logic              valid;
    logic              below;
    logic              x0_odd;
    logic              x1_odd;
    logic              y0_odd;
    logic              y1_odd;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } blend_ctl_t;

endpackage

// File: design/bbi_locate.sv
// ----------------------------------------------------------------------------
// bbi_locate
// Maps one Q1.15 direction cosine onto the grid: cell index, clamped upper
// neighbour and Q0.16 fraction.
// ----------------------------------------------------------------------------
module bbi_locate (
  input  logic [bbi_pkg::COORD_W-1:0]         side_m1_i,
  input  logic signed [bbi_pkg::SAMPLE_W-1:0] cosine_i,
  output bbi_pkg::loc_t                       loc_o
);
  import bbi_pkg::*;

  logic [FRAC_W-1:0]         unit_pos;
  logic [COORD_W+FRAC_W-1:0] grid_pos;
  logic [COORD_W:0]          next_idx;

  // c/2 + 1/2 in unsigned Q0.16 is the cosine with its sign bit flipped
  assign unit_pos = {~cosine_i[SAMPLE_W-1], cosine_i[SAMPLE_W-2:0]};

  // grid position in Q.16
  assign grid_pos = (COORD_W+FRAC_W)'(side_m1_i) * (COORD_W+FRAC_W)'(unit_pos);

  // upper neighbour clamped at the last grid point
  assign next_idx = {1'b0, grid_pos[COORD_W+FRAC_W-1:FRAC_W]} + (COORD_W+1)'(1);

  always_comb begin
    loc_o.i0   = grid_pos[COORD_W+FRAC_W-1:FRAC_W];
    loc_o.frac = grid_pos[FRAC_W-1:0];
    if (next_idx > {1'b0, side_m1_i}) begin
      loc_o.i1 = side_m1_i;
    end else begin
      loc_o.i1 = next_idx[COORD_W-1:0];
    end
  end

endmodule

// File: design/bbi_bank_mem.sv
// ----------------------------------------------------------------------------
// bbi_bank_mem
// One bank of the beam table: single port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module bbi_bank_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [bbi_pkg::BANK_AW-1:0]  addr_i,
  input  logic [bbi_pkg::SAMPLE_W-1:0] wdata_i,
  output logic [bbi_pkg::SAMPLE_W-1:0] rdata_o
);
  import bbi_pkg::*;

  logic [SAMPLE_W-1:0] mem [BANK_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  // write on load, otherwise read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bbi_blend.sv
// ----------------------------------------------------------------------------
// bbi_blend
// Interpolation datapath: picks the four neighbours from the bank words,
// blends along x, then along y, rounds and drives the result strobe.
// ----------------------------------------------------------------------------
module bbi_blend (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bbi_pkg::blend_ctl_t          ctl_i,
  input  bbi_pkg::quad_t               bank_rdata_i,
  output logic                         done_o,
  output logic [bbi_pkg::SAMPLE_W-1:0] response_o,
  output logic                         below_horizon_o
);
  import bbi_pkg::*;

  localparam logic signed [ACC_W-1:0] RoundBias = ACC_W'(1) <<< (ROW_W - 1);

  sample_t                    s00, s01, s10, s11;
  logic signed [SAMPLE_W:0]   diff0, diff1;
  logic signed [FRAC_W:0]     wx, wy;
  logic signed [ROW_W+1:0]    prod0, prod1, sum0, sum1;
  logic signed [ROW_W-1:0]    base0, base1;
  logic signed [ROW_W-1:0]    r0_d, r1_d, r0_q, r1_q;
  logic signed [ROW_W:0]      diffr;
  logic signed [ACC_W+1:0]    prodv, sumv;
  logic signed [ACC_W-1:0]    basev, v_d, v_q, rounded;
  logic [SAMPLE_W-1:0]        response_d;
  logic                       s3_valid_q, s3_below_q, s4_valid_q, s4_below_q;
  logic [FRAC_W-1:0]          s3_fy_q;
  logic                       done_q, below_q;
  logic [SAMPLE_W-1:0]        response_q;

  // neighbour selection by row and column parity
  assign s00 = sample_t'(bank_rdata_i[{ctl_i.y0_odd, ctl_i.x0_odd}]);
  assign s01 = sample_t'(bank_rdata_i[{ctl_i.y0_odd, ctl_i.x1_odd}]);
  assign s10 = sample_t'(bank_rdata_i[{ctl_i.y1_odd, ctl_i.x0_odd}]);
  assign s11 = sample_t'(bank_rdata_i[{ctl_i.y1_odd, ctl_i.x1_odd}]);

  // x blend as a*2^16 + (b-a)*fx
  assign wx    = {1'b0, ctl_i.fx};
  assign diff0 = (SAMPLE_W+1)'(s01) - (SAMPLE_W+1)'(s00);
  assign diff1 = (SAMPLE_W+1)'(s11) - (SAMPLE_W+1)'(s10);
  assign prod0 = diff0 * wx;
  assign prod1 = diff1 * wx;
  assign base0 = {s00, {FRAC_W{1'b0}}};
  assign base1 = {s10, {FRAC_W{1'b0}}};
  assign sum0  = (ROW_W+2)'(base0) + prod0;
  assign sum1  = (ROW_W+2)'(base1) + prod1;
  assign r0_d  = sum0[ROW_W-1:0];
  assign r1_d  = sum1[ROW_W-1:0];

  always_ff @(posedge clk_i) begin
    r0_q    <= r0_d;
    r1_q    <= r1_d;
    s3_fy_q <= ctl_i.fy;
  end

  // y blend as r0*2^16 + (r1-r0)*fy
  assign wy    = {1'b0, s3_fy_q};
  assign diffr = (ROW_W+1)'(r1_q) - (ROW_W+1)'(r0_q);
  assign prodv = diffr * wy;
  assign basev = {r0_q, {FRAC_W{1'b0}}};
  assign sumv  = (ACC_W+2)'(basev) + prodv;
  assign v_d   = sumv[ACC_W-1:0];

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  // round half up; a convex blend stays inside Q1.15, so no overflow
  assign rounded = v_q + RoundBias;

  always_comb begin
    if (s4_below_q) begin
      response_d = '0;
    end else begin
      response_d = rounded[ACC_W-1:ROW_W];
    end
  end

  always_ff @(posedge clk_i) begin
    response_q <= response_d;
    below_q    <= s4_below_q;
  end

  // control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s3_below_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s4_below_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s3_valid_q <= ctl_i.valid;
      s3_below_q <= ctl_i.below;
      s4_valid_q <= s3_valid_q;
      s4_below_q <= s3_below_q;
      done_q     <= s4_valid_q;
    end
  end

  assign done_o          = done_q;
  assign response_o      = response_q;
  assign below_horizon_o = below_q;

endmodule

// File: design/beam_bilinear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// beam_bilinear_interpolator_unit
// Per-antenna beam grids with bilinear lookup of the response for a sky
// direction.
// ----------------------------------------------------------------------------
// One word is taken in every clock cycle: busy never rises, and loads and
// queries may follow each other in any mix. A query's result appears on
// done_o once it has passed the input, bank read, x blend, y blend and output
// registers, and is shown for a single cycle; loads give no result. The table
// sits in four single port RAM banks split by row and column parity, so the
// four neighbours of a cell are read together in one cycle and each word uses
// its bank once. Loads and queries reach the banks in the same pipeline slot,
// so a query sees every load taken before it. The table needs no clearing
// pass after reset: each entry must be loaded before a query reads it.
// grid_side may only be written while no query is in flight.
// ----------------------------------------------------------------------------
module beam_bilinear_interpolator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type_i,
  input  logic [bbi_pkg::COORD_W-1:0]         grid_x_i,
  input  logic [bbi_pkg::COORD_W-1:0]         grid_y_i,
  input  logic [bbi_pkg::ANT_W-1:0]           antenna_i,
  input  logic signed [bbi_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic signed [bbi_pkg::SAMPLE_W-1:0] dir_x_i,
  input  logic signed [bbi_pkg::SAMPLE_W-1:0] dir_y_i,
  input  logic signed [bbi_pkg::SAMPLE_W-1:0] dir_z_i,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bbi_pkg::SIDE_W-1:0]          cfg_grid_side_i,
  // result
  output logic                                done_o,
  output logic signed [bbi_pkg::SAMPLE_W-1:0] response_o,
  output logic                                below_horizon_o
);
  import bbi_pkg::*;

  logic [SIDE_W-1:0]   side_q;
  logic [SIDE_W-1:0]   side_clamped;
  logic [COORD_W-1:0]  side_m1;
  logic                accept;
  logic                s1_valid_q;
  logic                s1_type_q;
  logic [COORD_W-1:0]  s1_gx_q, s1_gy_q;
  logic [ANT_W-1:0]    s1_ant_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  sample_t             s1_dx_q, s1_dy_q, s1_dz_q;
  loc_t                loc_x, loc_y;
  blend_ctl_t          blend_ctl_d, blend_ctl_q;
  quad_t               bank_rdata;
  logic [SAMPLE_W-1:0] response_w;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // grid side register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= GRID_SIDE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      side_q <= cfg_grid_side_i;
    end
  end

  // side in use clamped to 2..GRID_SIDE_MAX, kept as side minus one
  always_comb begin
    if (side_q < SIDE_W'(2)) begin
      side_clamped = SIDE_W'(2);
    end else if (side_q > SIDE_W'(GRID_SIDE_MAX)) begin
      side_clamped = SIDE_W'(GRID_SIDE_MAX);
    end else begin
      side_clamped = side_q;
    end
    side_m1 = COORD_W'(side_clamped - SIDE_W'(1));
  end

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_type_q   <= req_type_i;
      s1_gx_q     <= grid_x_i;
      s1_gy_q     <= grid_y_i;
      s1_ant_q    <= antenna_i;
      s1_sample_q <= sample_value_i;
      s1_dx_q     <= dir_x_i;
      s1_dy_q     <= dir_y_i;
      s1_dz_q     <= dir_z_i;
    end
  end

  // grid location on both axes
  bbi_locate u_locate_x (
    .side_m1_i (side_m1),
    .cosine_i  (s1_dx_q),
    .loc_o     (loc_x)
  );

  bbi_locate u_locate_y (
    .side_m1_i (side_m1),
    .cosine_i  (s1_dy_q),
    .loc_o     (loc_y)
  );

  // table banks: each neighbour lands in the bank of its row and column parity
  for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
    localparam logic RowOdd = 1'(gb / 2);
    localparam logic ColOdd = 1'(gb % 2);

    logic [COORD_W-1:0] q_row, q_col;
    logic [BANK_AW-1:0] addr;
    logic               we;

    assign q_row = (loc_y.i0[0] == RowOdd) ? loc_y.i0 : loc_y.i1;
    assign q_col = (loc_x.i0[0] == ColOdd) ? loc_x.i0 : loc_x.i1;
    assign we    = s1_valid_q && (s1_type_q == REQ_LOAD) &&
                   (s1_gy_q[0] == RowOdd) && (s1_gx_q[0] == ColOdd);

    always_comb begin
      if (s1_type_q == REQ_LOAD) begin
        addr = {s1_ant_q, s1_gy_q[COORD_W-1:1], s1_gx_q[COORD_W-1:1]};
      end else begin
        addr = {s1_ant_q, q_row[COORD_W-1:1], q_col[COORD_W-1:1]};
      end
    end

    bbi_bank_mem u_mem (
      .clk_i   (clk_i),
      .we_i    (we),
      .addr_i  (addr),
      .wdata_i (s1_sample_q),
      .rdata_o (bank_rdata[gb])
    );
  end

  // query control, aligned with the bank read data
  always_comb begin
    blend_ctl_d.valid  = s1_valid_q && (s1_type_q == REQ_QUERY);
    blend_ctl_d.below  = s1_dz_q[SAMPLE_W-1] || (s1_dz_q == '0);
    blend_ctl_d.x0_odd = loc_x.i0[0];
    blend_ctl_d.x1_odd = loc_x.i1[0];
    blend_ctl_d.y0_odd = loc_y.i0[0];
    blend_ctl_d.y1_odd = loc_y.i1[0];
    blend_ctl_d.fx     = loc_x.frac;
    blend_ctl_d.fy     = loc_y.frac;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_ctl_q <= '0;
    end else begin
      blend_ctl_q <= blend_ctl_d;
    end
  end

  bbi_blend u_blend (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (blend_ctl_q),
    .bank_rdata_i    (bank_rdata),
    .done_o          (done_o),
    .response_o      (response_w),
    .below_horizon_o (below_horizon_o)
  );

  assign response_o = sample_t'(response_w);

endmodule
